### rtl/uva_pkg.sv
// Package: types, constants and arctangent table for the unit vector angle pipeline.
package uva_pkg;

  localparam int FracBits    = 30;
  localparam int CordicSteps = 32;
  localparam int WorkFrac    = 58;
  localparam int NSteps      = (CordicSteps > 60) ? 60 : CordicSteps;
  localparam int ScaleSh     = WorkFrac - FracBits;

  // Square root pipeline depth: one root bit per stage for a 64-bit radicand.
  localparam int SqrtStages = 32;

  // CORDIC datapath width: values up to about 2^60, plus growth and sign.
  localparam int CW = 64;
  // Angle accumulator width (Q.32 with sign and headroom).
  localparam int ZW = 36;

  localparam logic signed [ZW-1:0] PiQ32     = 36'sd13493037704;
  localparam logic signed [ZW-1:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic [30:0]          PiQ29     = 31'd1686629713;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } uva_in_t;

  typedef struct packed {
    logic [30:0] angle;
    logic        domain_flag;
  } uva_out_t;

  // Sideband that rides along the CORDIC stages.
  typedef struct packed {
    logic acos_br;  // acos branch taken
    logic neg_d;    // dot product negative
    logic flag;     // asin argument saturated
  } uva_side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0:  r = 36'sd3373259426;
      1:  r = 36'sd1991351318;
      2:  r = 36'sd1052175346;
      3:  r = 36'sd534100635;
      4:  r = 36'sd268086748;
      5:  r = 36'sd134174063;
      6:  r = 36'sd67103403;
      7:  r = 36'sd33553749;
      8:  r = 36'sd16777131;
      9:  r = 36'sd8388597;
      10: r = 36'sd4194303;
      default: begin
        if (i <= 32) r = ZW'(64'sd1 <<< (32 - i));
        else         r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/uva_isqrt.sv
// Pipelined integer square root: one root bit per stage, 32 stages.
module uva_isqrt (
  input  logic        clk,
  input  logic [63:0] in_val,
  output logic [31:0] out_root
);
  import uva_pkg::*;

  localparam int NS = SqrtStages;

  logic [63:0] rem_r  [NS];
  logic [31:0] root_r [NS];
  logic [63:0] rem_nxt  [NS];
  logic [31:0] root_nxt [NS];

  // Restoring square root: each stage decides one root bit from the top down.
  always_comb begin
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;
    for (int s = 0; s < NS; s++) begin
      rem_in  = (s == 0) ? in_val : rem_r[(s == 0) ? 0 : s - 1];
      root_in = (s == 0) ? 32'd0  : root_r[(s == 0) ? 0 : s - 1];
      trial   = {2'b00, 32'd0, root_in} << (NS - s);
      trial   = trial | (66'd1 << (2 * (NS - 1 - s)));
      if ({2'b00, rem_in} >= trial) begin
        rem_nxt[s]  = rem_in - trial[63:0];
        root_nxt[s] = root_in | (32'd1 << (NS - 1 - s));
      end else begin
        rem_nxt[s]  = rem_in;
        root_nxt[s] = root_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
  end

  assign out_root = root_r[NS-1];

endmodule

### rtl/uva_front.sv
// Front end: products, dot and cross products, squares and branch select.
module uva_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  uva_pkg::uva_in_t    in_data,
  output logic                out_vld,
  output logic [63:0]         out_rad_y,   // radicand for the y operand root
  output logic [63:0]         out_rad_x,   // radicand for the x operand root
  output logic signed [33:0]  out_d,
  output uva_pkg::uva_side_t  out_side
);
  import uva_pkg::*;

  localparam logic signed [33:0] One  = 34'sd1 <<< FracBits;
  localparam logic signed [33:0] Half = 34'sd1 <<< (FracBits - 1);
  localparam logic [63:0]        OneSq = 64'd1 << (2 * FracBits);

  // Stage 1: nine floored products.
  logic signed [33:0] p_r [9];
  logic signed [33:0] p_nxt [9];
  logic               v1_r;

  function automatic logic signed [33:0] mulf(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] m;
    m = a * b;
    return 34'(m >>> FracBits);
  endfunction

  always_comb begin
    p_nxt[0] = mulf(in_data.a_x, in_data.b_x);
    p_nxt[1] = mulf(in_data.a_y, in_data.b_y);
    p_nxt[2] = mulf(in_data.a_z, in_data.b_z);
    p_nxt[3] = mulf(in_data.a_y, in_data.b_z);
    p_nxt[4] = mulf(in_data.a_z, in_data.b_y);
    p_nxt[5] = mulf(in_data.a_z, in_data.b_x);
    p_nxt[6] = mulf(in_data.a_x, in_data.b_z);
    p_nxt[7] = mulf(in_data.a_x, in_data.b_y);
    p_nxt[8] = mulf(in_data.a_y, in_data.b_x);
  end

  // Stage 2: dot and cross sums.
  logic signed [35:0] d_r, c0_r, c1_r, c2_r;
  logic               v2_r;

  // Stage 3: squares.
  logic [71:0]        dd_r, s0_r, s1_r, s2_r;
  logic signed [35:0] d3_r;
  logic               big3_r, v3_r;

  // Stage 4: radicands and branch.
  logic [63:0]        rady_r, radx_r;
  logic signed [33:0] d4_r;
  uva_side_t          side4_r;
  logic               v4_r;

  logic               sat_c;
  logic [73:0]        sq_sum;
  logic               acos_c;

  always_comb begin
    sq_sum = {2'b00, s0_r} + {2'b00, s1_r} + {2'b00, s2_r};
    acos_c = (d3_r >= 36'(-Half)) && (d3_r <= 36'(Half));
    sat_c  = big3_r || (sq_sum > {10'd0, OneSq});
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) p_r[k] <= p_nxt[k];
    d_r  <= 36'(p_r[0]) + 36'(p_r[1]) + 36'(p_r[2]);
    c0_r <= 36'(p_r[3]) - 36'(p_r[4]);
    c1_r <= 36'(p_r[5]) - 36'(p_r[6]);
    c2_r <= 36'(p_r[7]) - 36'(p_r[8]);

    dd_r   <= 72'(d_r * d_r);
    s0_r   <= 72'(c0_r * c0_r);
    s1_r   <= 72'(c1_r * c1_r);
    s2_r   <= 72'(c2_r * c2_r);
    d3_r   <= d_r;
    big3_r <= (c0_r > 36'(One)) || (c0_r < -36'(One)) ||
              (c1_r > 36'(One)) || (c1_r < -36'(One)) ||
              (c2_r > 36'(One)) || (c2_r < -36'(One));

    d4_r          <= 34'(d3_r);
    side4_r.acos_br <= acos_c;
    side4_r.neg_d   <= d3_r[35];
    side4_r.flag    <= !acos_c && sat_c;
    if (acos_c) begin
      rady_r <= 64'd0;
      radx_r <= OneSq - dd_r[63:0];
    end else if (sat_c) begin
      rady_r <= OneSq;  // root is one
      radx_r <= 64'd0;
    end else begin
      rady_r <= sq_sum[63:0];
      radx_r <= OneSq - sq_sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_vld   = v4_r;
  assign out_rad_y = rady_r;
  assign out_rad_x = radx_r;
  assign out_d     = d4_r;
  assign out_side  = side4_r;

endmodule

### rtl/uva_cordic.sv
// Pipelined vectoring CORDIC atan2 with final angle fold, rounding and clamp.
module uva_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [33:0] in_x,
  input  logic signed [33:0] in_y,
  input  uva_pkg::uva_side_t in_side,
  output logic               out_vld,
  output uva_pkg::uva_out_t  out_res
);
  import uva_pkg::*;

  // Stage 0: scale and pre-rotate.
  logic signed [CW-1:0] x_r [NSteps+1];
  logic signed [CW-1:0] y_r [NSteps+1];
  logic signed [ZW-1:0] z_r [NSteps+1];
  uva_side_t            sd_r [NSteps+1];
  logic                 v_r  [NSteps+2];

  logic signed [CW-1:0] xs_c, ys_c;
  logic signed [CW-1:0] x_nxt [NSteps];
  logic signed [CW-1:0] y_nxt [NSteps];
  logic signed [ZW-1:0] z_nxt [NSteps];

  assign xs_c = CW'(in_x) <<< ScaleSh;
  assign ys_c = CW'(in_y) <<< ScaleSh;

  always_comb begin
    for (int i = 0; i < NSteps; i++) begin
      if (!y_r[i][CW-1]) begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i] = z_r[i] + atan_entry(i);
      end else begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i] = z_r[i] - atan_entry(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xs_c[CW-1]) begin
      x_r[0] <= ys_c;
      y_r[0] <= -xs_c;
      z_r[0] <= HalfPiQ32;
    end else begin
      x_r[0] <= xs_c;
      y_r[0] <= ys_c;
      z_r[0] <= '0;
    end
    sd_r[0] <= in_side;
    for (int i = 0; i < NSteps; i++) begin
      x_r[i+1]  <= x_nxt[i];
      y_r[i+1]  <= y_nxt[i];
      z_r[i+1]  <= z_nxt[i];
      sd_r[i+1] <= sd_r[i];
    end
  end

  // Final stage: fold for obtuse asin case, round to Q2.29, clamp.
  logic signed [ZW-1:0] zf;
  logic signed [ZW-1:0] ang;
  uva_out_t             res_r;
  uva_side_t            sdl;

  always_comb begin
    sdl = sd_r[NSteps];
    zf  = z_r[NSteps];
    if (!sdl.acos_br && sdl.neg_d) zf = PiQ32 - zf;
    ang = (zf + ZW'(4)) >>> 3;
  end

  always_ff @(posedge clk) begin
    if (ang[ZW-1])                 res_r.angle <= '0;
    else if (ang > ZW'(PiQ29))     res_r.angle <= PiQ29;
    else                           res_r.angle <= ang[30:0];
    res_r.domain_flag <= sdl.flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSteps + 2; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
      for (int i = 0; i < NSteps + 1; i++) v_r[i+1] <= v_r[i];
    end
  end

  assign out_vld = v_r[NSteps+1];
  assign out_res = res_r;

endmodule

### rtl/unit_vector_angle.sv
// Top level: angle between two 3-D unit vectors, fully pipelined.
//
// channel | ports                         | handshake
// input   | in_data (a/b vectors, Q2.30)  | start, busy (busy held low)
// result  | out_data (angle Q2.29, flag)  | out_strobe, one cycle, no stall
//
// One beat enters every cycle; busy is always low. The pipeline holds
// 4 front stages (products, sums, squares, radicands), 32 square root
// stages, 1 + CordicSteps CORDIC stages and 1 output stage.
// Reset clears only the valid bits; payload registers run free.
// The receiver cannot stall, so nothing is ever held back.
module unit_vector_angle (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  uva_pkg::uva_in_t  in_data,
  output logic              out_strobe,
  output uva_pkg::uva_out_t out_data
);
  import uva_pkg::*;

  localparam int SqDelay = SqrtStages;

  logic               f_vld;
  logic [63:0]        rad_y, rad_x;
  logic signed [33:0] f_d;
  uva_side_t          f_side;

  // Never refuse a beat: every stage advances each cycle.
  assign busy = 1'b0;

  uva_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_data  (in_data),
    .out_vld  (f_vld),
    .out_rad_y(rad_y),
    .out_rad_x(rad_x),
    .out_d    (f_d),
    .out_side (f_side)
  );

  logic [31:0] root_y, root_x;

  uva_isqrt u_sqrt_y (.clk(clk), .in_val(rad_y), .out_root(root_y));
  uva_isqrt u_sqrt_x (.clk(clk), .in_val(rad_x), .out_root(root_x));

  // Delay d, sideband and valid alongside the root pipelines.
  logic signed [33:0] d_dl_r    [SqDelay];
  uva_side_t          side_dl_r [SqDelay];
  logic               vld_dl_r  [SqDelay];

  always_ff @(posedge clk) begin
    d_dl_r[0]    <= f_d;
    side_dl_r[0] <= f_side;
    for (int i = 1; i < SqDelay; i++) begin
      d_dl_r[i]    <= d_dl_r[i-1];
      side_dl_r[i] <= side_dl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SqDelay; i++) vld_dl_r[i] <= 1'b0;
    end else begin
      vld_dl_r[0] <= f_vld;
      for (int i = 1; i < SqDelay; i++) vld_dl_r[i] <= vld_dl_r[i-1];
    end
  end

  // acos: atan2(sqrt(1-d^2), d); asin: atan2(|c|, sqrt(1-|c|^2)).
  uva_side_t          c_side;
  logic signed [33:0] c_x, c_y;

  always_comb begin
    c_side = side_dl_r[SqDelay-1];
    if (c_side.acos_br) begin
      c_x = d_dl_r[SqDelay-1];
      c_y = {2'b00, root_x};
    end else begin
      c_x = {2'b00, root_x};
      c_y = {2'b00, root_y};
    end
  end

  uva_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (vld_dl_r[SqDelay-1]),
    .in_x   (c_x),
    .in_y   (c_y),
    .in_side(c_side),
    .out_vld(out_strobe),
    .out_res(out_data)
  );

`ifndef SYNTH
  // The result never exceeds pi.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.angle <= PiQ29) else $error("angle above pi");

  // No result may appear right after reset without an entering beat.
  a_no_spurious: assert property (@(posedge clk)
    !rst_n |=> !out_strobe) else $error("strobe after reset");

  // acos branch never raises the domain flag.
  a_acos_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_dl_r[SqDelay-1] && c_side.acos_br |-> !c_side.flag)
    else $error("flag in acos branch");
`endif

endmodule

### test/tb_top.sv
// Testbench for unit_vector_angle: directed and random vector pairs checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import uva_pkg::*;

  localparam int Latency = 4 + SqrtStages + 1 + NSteps + 1;
  localparam int RandItems = 1900;
  localparam longint OneQ = 64'sd1 << FracBits;

  // Check kinds for the directed rows: predictor only, or the typed-in result too.
  typedef enum logic [1:0] {
    CHK_PRED,   // compare against the predictor only
    CHK_TYPED   // typed-in result must also match
  } row_kind_t;

  typedef struct {
    uva_in_t   vec;
    row_kind_t kind;
    uva_out_t  typed;
  } vec_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  uva_in_t  in_data;
  logic     out_strobe;
  uva_out_t out_data;

  uva_out_t angle_q[$];
  int       err_cnt;
  int       sender_idle_pct;
  vec_row_t vec_tbl[$];

  unit_vector_angle i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Floor shift right for signed 64-bit values.
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return floor_shr(a * b, FracBits);
  endfunction

  // Bitwise integer square root, floor.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_q32(input int i);
    longint tbl [11] = '{64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748,
                         134174063, 67103403, 33553749, 16777131, 8388597, 4194303};
    if (i < 11) return tbl[i];
    if (i <= 32) return 64'sd1 << (32 - i);
    return 0;
  endfunction

  // Vectoring CORDIC atan2(y, x); result in Q.32 radians.
  function automatic longint vec_atan2(input longint x, input longint y);
    longint z, t, xs, ys;
    z = 0;
    x = x <<< ScaleSh;
    y = y <<< ScaleSh;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 64'sd6746518852;
    end
    for (int i = 0; i < NSteps; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q32(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q32(i);
      end
    end
    return z;
  endfunction

  // Angle between the two vectors, as the block computes it.
  function automatic uva_out_t vec_angle(input uva_in_t v);
    longint a0, a1, a2, b0, b1, b2, d, c0, c1, c2, z, ang, ny, nx;
    longint unsigned one_sq, sq;
    logic sat;
    uva_out_t r;
    a0 = v.a_x; a1 = v.a_y; a2 = v.a_z;
    b0 = v.b_x; b1 = v.b_y; b2 = v.b_z;
    one_sq = longint'(OneQ) * longint'(OneQ);
    sat = 1'b0;
    d = fx_mul(a0, b0) + fx_mul(a1, b1) + fx_mul(a2, b2);
    if (d >= -(OneQ >>> 1) && d <= (OneQ >>> 1)) begin
      z = vec_atan2(d, longint'(int_sqrt(one_sq - longint'(d * d))));
    end else begin
      c0 = fx_mul(a1, b2) - fx_mul(a2, b1);
      c1 = fx_mul(a2, b0) - fx_mul(a0, b2);
      c2 = fx_mul(a0, b1) - fx_mul(a1, b0);
      if (c0 > OneQ || c0 < -OneQ || c1 > OneQ || c1 < -OneQ ||
          c2 > OneQ || c2 < -OneQ) sat = 1'b1;
      ny = OneQ;
      nx = 0;
      if (!sat) begin
        sq = longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2);
        if (sq > one_sq) begin
          sat = 1'b1;
        end else begin
          ny = int_sqrt(sq);
          nx = int_sqrt(one_sq - sq);
        end
      end
      z = vec_atan2(nx, ny);
      if (d < 0) z = 64'sd13493037704 - z;
    end
    ang = floor_shr(z + 4, 3);
    if (ang < 0) ang = 0;
    if (ang > longint'(PiQ29)) ang = PiQ29;
    r.angle       = ang[30:0];
    r.domain_flag = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  // Drive one beat; the block never raises busy, but honor it anyway.
  task automatic send_vec(input uva_in_t v, input row_kind_t kind, input uva_out_t typed);
    uva_out_t pred;
    pred = vec_angle(v);
    if (kind == CHK_TYPED && pred != typed)
      report_mismatch("typed row", typed, pred);
    in_data <= v;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    angle_q.push_back(pred);
    // Random gap after a beat, as often as sender_idle_pct sets.
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  function automatic logic signed [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'sd1073741824 : -32'sd1073741824;
      1: return 32'($urandom_range(2048)) - 32'sd1024;
      2: return $urandom;
      default: return 32'(signed'($urandom_range(32'h7FFF_FFFF)) - 32'sd1073741824);
    endcase
  endfunction

  // Roughly unit vectors: random components scaled to unit length; some pairs raw.
  function automatic uva_in_t rand_vec();
    uva_in_t v;
    real ax, ay, az, bx, by, bz, na, nb;
    if ($urandom_range(9) == 0) begin
      v = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      return v;
    end
    ax = real'(int'($urandom)) ; ay = real'(int'($urandom)); az = real'(int'($urandom));
    bx = real'(int'($urandom)) ; by = real'(int'($urandom)); bz = real'(int'($urandom));
    // Steer part of the pairs to near-parallel or near-opposite.
    if ($urandom_range(2) == 0) begin
      na = ($urandom_range(1) ? 1.0 : -1.0);
      bx = ax * na + real'(int'($urandom_range(2000000))) - 1.0e6;
      by = ay * na; bz = az * na;
    end
    na = $sqrt(ax * ax + ay * ay + az * az) + 1.0;
    nb = $sqrt(bx * bx + by * by + bz * bz) + 1.0;
    v.a_x = $rtoi(ax / na * 1073741824.0); v.a_y = $rtoi(ay / na * 1073741824.0);
    v.a_z = $rtoi(az / na * 1073741824.0); v.b_x = $rtoi(bx / nb * 1073741824.0);
    v.b_y = $rtoi(by / nb * 1073741824.0); v.b_z = $rtoi(bz / nb * 1073741824.0);
    return v;
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    uva_out_t want;
    if (rst_n && out_strobe) begin
      if (angle_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.angle, -1);
      end else begin
        want = angle_q.pop_front();
        if (out_data.angle !== want.angle)
          report_mismatch("angle", out_data.angle, want.angle);
        if (out_data.domain_flag !== want.domain_flag)
          report_mismatch("domain_flag", out_data.domain_flag, want.domain_flag);
      end
    end
  end

  // Build the directed table: extremes, both branches, saturation cases.
  task automatic fill_table();
    longint o;
    uva_out_t pi_typed, zero_typed, half_pi_sat, half_pi;
    o = OneQ;
    pi_typed    = '{angle: PiQ29, domain_flag: 1'b0};
    zero_typed  = '{angle: 31'd0, domain_flag: 1'b0};
    half_pi_sat = '{angle: 31'd843314857, domain_flag: 1'b1};
    half_pi     = '{angle: 31'd843314857, domain_flag: 1'b0};
    // Same vector: angle zero.
    vec_tbl.push_back('{'{o, 0, 0, o, 0, 0}, CHK_TYPED, zero_typed});
    // Opposite vectors: angle pi.
    vec_tbl.push_back('{'{o, 0, 0, -o, 0, 0}, CHK_TYPED, pi_typed});
    vec_tbl.push_back('{'{0, 0, -o, 0, 0, o}, CHK_TYPED, pi_typed});
    // Orthogonal: acos branch at d = 0.
    vec_tbl.push_back('{'{o, 0, 0, 0, o, 0}, CHK_TYPED, half_pi});
    vec_tbl.push_back('{'{0, o, 0, 0, 0, -o}, CHK_PRED, zero_typed});
    // Dot exactly at the branch bounds and one step beyond them.
    vec_tbl.push_back('{'{o, 0, 0, o >>> 1, o, 0}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{o, 0, 0, -(o >>> 1), o, 0}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{o, 0, 0, (o >>> 1) + 1, 0, o}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{o, 0, 0, -(o >>> 1) - 1, 0, o}, CHK_PRED, zero_typed});
    // Cross product components beyond one: asin argument saturates (second row has d = 0, acos branch).
    vec_tbl.push_back('{'{o, o, o, o, -o, o}, CHK_TYPED, half_pi_sat});
    vec_tbl.push_back('{'{o, o, 0, o, -o, o}, CHK_PRED, zero_typed});
    // Cross norm above one without any single component above one.
    vec_tbl.push_back('{'{o, o, 0, o, 0, o}, CHK_PRED, zero_typed});
    // Raw extremes of the 32-bit fields.
    vec_tbl.push_back('{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 32'sh80000000, 32'sh80000000}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                          32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{-1, -1, -1, -1, -1, -1}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{0, 0, 0, 0, 0, 0}, CHK_TYPED, half_pi});
    // Near-parallel and near-opposite, small cross product.
    vec_tbl.push_back('{'{o, 0, 0, o - 1, 46341, 0}, CHK_PRED, zero_typed});
    vec_tbl.push_back('{'{o, 0, 0, -o + 1, 0, -46341}, CHK_PRED, zero_typed});
    // Non-unit: d far below minus one, cross zero -> clamp path.
    vec_tbl.push_back('{'{2 * o - 1, 0, 0, -2 * o, 0, 0}, CHK_PRED, zero_typed});
  endtask

  initial begin
    uva_out_t none;
    none            = '0;
    err_cnt         = 0;
    sender_idle_pct = 0;
    start           = 1'b0;
    in_data         = '0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    fill_table();
    foreach (vec_tbl[i]) send_vec(vec_tbl[i].vec, vec_tbl[i].kind, vec_tbl[i].typed);

    // Hold off until the pipeline drains once.
    start <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);

    // Three phases: sender idles 30%, then 59%, then not at all.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 59 : 0;
      for (int n = 0; n < RandItems / 3; n++) send_vec(rand_vec(), CHK_PRED, none);
    end
    start <= 1'b0;

    while (angle_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (err_cnt == 0)
      $display("[unit_vector_angle] OK");
    else
      $display("[unit_vector_angle] ERROR");
    $finish;
  end

  // Watchdog: generous fixed bound.
  initial begin
    #2000000;
    $display("[unit_vector_angle] ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/uva_pkg.sv
rtl/uva_isqrt.sv
rtl/uva_front.sv
rtl/uva_cordic.sv
rtl/unit_vector_angle.sv
test/tb_top.sv
